// ===== design/dfmt_pkg.sv =====
package dfmt_pkg;

    localparam int MAX_FIELD  = 64;
    localparam int MAX_DIGITS = 20;
    localparam int MAG_W      = 64;
    localparam int WIDTH_W    = 7;
    localparam int PREC_W     = 6;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;

    localparam int CNT_W  = $clog2(MAG_W);
    localparam int ND_W   = $clog2(MAX_DIGITS + 1);
    localparam int CALC_W = $clog2(MAX_FIELD + (1 << WIDTH_W) + (1 << PREC_W) + MAX_DIGITS + 2);

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

    typedef logic [CALC_W-1:0]  calc_t;
    typedef logic [DIGIT_W-1:0] digit_t;

    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift_up;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_NORM,
        ST_PREP,
        ST_EMIT
    } fmt_state_t;

endpackage

// ===== design/dfmt_digit_cell.sv =====
module dfmt_digit_cell (
    input  logic                clk,
    input  dfmt_pkg::cell_ctrl_t ctrl,
    input  logic                bit_in,
    input  dfmt_pkg::digit_t    digit_in,
    output logic                bit_out,
    output dfmt_pkg::digit_t    digit
);

    dfmt_pkg::digit_t digit_reg;
    dfmt_pkg::digit_t digit_next;
    dfmt_pkg::digit_t adj;

    // add-3 correction before the shift
    always_comb
    begin
        if (digit_reg >= dfmt_pkg::digit_t'(5))
        begin
            adj = digit_reg + dfmt_pkg::digit_t'(3);
        end
        else
        begin
            adj = digit_reg;
        end
    end

    always_comb
    begin
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[dfmt_pkg::DIGIT_W-2:0], bit_in};
        end
        else if (ctrl.shift_up)
        begin
            digit_next = digit_in;
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign bit_out = adj[dfmt_pkg::DIGIT_W-1];
    assign digit   = digit_reg;

endmodule

// ===== design/dfmt_digit_chain.sv =====
module dfmt_digit_chain (
    input  logic                 clk,
    input  dfmt_pkg::cell_ctrl_t ctrl,
    input  logic                 bit_in,
    output dfmt_pkg::digit_t     top_digit
);

    logic             carry [dfmt_pkg::MAX_DIGITS+1];
    dfmt_pkg::digit_t dig   [dfmt_pkg::MAX_DIGITS];
    dfmt_pkg::digit_t lower [dfmt_pkg::MAX_DIGITS];

    assign carry[0] = bit_in;

    // cell 0 holds the least significant digit
    for (genvar i = 0; i < dfmt_pkg::MAX_DIGITS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign lower[i] = '0;
        end
        else
        begin : g_rest
            assign lower[i] = dig[i-1];
        end

        dfmt_digit_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .bit_in   (carry[i]),
            .digit_in (lower[i]),
            .bit_out  (carry[i+1]),
            .digit    (dig[i])
        );
    end

    assign top_digit = dig[dfmt_pkg::MAX_DIGITS-1];

endmodule

// ===== design/decimal_field_formatter_unit.sv =====
// operation: the word is taken at the handshake, then shift-and-add-3 runs through the
// digit cells, one step per magnitude bit, leading zero digits are shifted out of the top cell,
// a setup state (ST_PREP) follows, then one character per cycle while the receiver does not stall
// input: no new word is taken until the last character of the current word has been emitted,
// or until the setup state has found an empty field
// reset: rst_n clears the state machine and the output valid; digit cells are not reset
module decimal_field_formatter_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [dfmt_pkg::MAG_W-1:0]          magnitude,
    input  logic                                negative,
    input  logic [dfmt_pkg::WIDTH_W-1:0]        field_width,
    input  logic                                precision_given,
    input  logic [dfmt_pkg::PREC_W-1:0]         min_digits,
    input  logic                                force_plus,
    input  logic                                space_sign,
    input  logic                                zero_pad,
    input  logic                                left_align,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dfmt_pkg::CHAR_W-1:0]         out_char,
    output logic                                last_char
);

    dfmt_pkg::fmt_state_t state_reg;
    dfmt_pkg::fmt_state_t state_next;

    logic [dfmt_pkg::MAG_W-1:0]   mag_reg;
    logic [dfmt_pkg::CNT_W-1:0]   conv_cnt_reg;
    logic [dfmt_pkg::ND_W-1:0]    nshift_reg;
    logic [dfmt_pkg::WIDTH_W-1:0] width_reg;
    logic [dfmt_pkg::PREC_W-1:0]  prec_reg;
    logic                         prec_on_reg;
    logic                         plus_reg;
    logic                         space_reg;
    logic                         zpad_reg;
    logic                         left_reg;
    logic                         neg_reg;
    logic                         zero_case_reg;

    dfmt_pkg::calc_t              len_reg;
    dfmt_pkg::calc_t              pad_reg;
    dfmt_pkg::calc_t              sign_pos_reg;
    dfmt_pkg::calc_t              dstart_reg;
    dfmt_pkg::calc_t              dend_reg;
    dfmt_pkg::calc_t              pos_reg;
    logic                         sign_on_reg;
    logic                         rspace_reg;
    logic [dfmt_pkg::CHAR_W-1:0]  sign_ch_reg;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [dfmt_pkg::CHAR_W-1:0]  out_char_reg;
    logic                         last_reg;

    dfmt_pkg::cell_ctrl_t         ctrl;
    dfmt_pkg::digit_t             top_digit;
    logic                         accept;
    logic                         conv_done;
    logic                         norm_more;
    logic                         slot_free;
    logic                         emit_load;
    logic                         emit_last;
    logic                         in_digits;
    logic [dfmt_pkg::CHAR_W-1:0]  emit_ch;

    dfmt_pkg::calc_t              width_s;
    dfmt_pkg::calc_t              nd;
    dfmt_pkg::calc_t              pz;
    dfmt_pkg::calc_t              body;
    dfmt_pkg::calc_t              pad;
    dfmt_pkg::calc_t              full;
    dfmt_pkg::calc_t              sign_len;
    logic                         rspace;
    logic                         sign_on;
    logic [dfmt_pkg::CHAR_W-1:0]  sign_ch;

    dfmt_digit_chain u_chain (
        .clk       (clk),
        .ctrl      (ctrl),
        .bit_in    (mag_reg[dfmt_pkg::MAG_W-1]),
        .top_digit (top_digit)
    );

    assign conv_done = (conv_cnt_reg == dfmt_pkg::CNT_W'(dfmt_pkg::MAG_W - 1));
    assign norm_more = (top_digit == '0) &&
                       (nshift_reg < dfmt_pkg::ND_W'(dfmt_pkg::MAX_DIGITS - 1));
    assign slot_free = !out_valid_reg || out_ready;
    assign emit_last = (pos_reg == len_reg - dfmt_pkg::calc_t'(1));

    // field layout
    always_comb
    begin
        if (neg_reg)
        begin
            sign_ch = dfmt_pkg::CH_MINUS;
        end
        else if (plus_reg)
        begin
            sign_ch = dfmt_pkg::CH_PLUS;
        end
        else
        begin
            sign_ch = dfmt_pkg::CH_SPACE;
        end
        sign_on  = neg_reg || plus_reg || space_reg;
        sign_len = dfmt_pkg::calc_t'(sign_on);

        if (width_reg > dfmt_pkg::WIDTH_W'(dfmt_pkg::MAX_FIELD))
        begin
            width_s = dfmt_pkg::calc_t'(dfmt_pkg::MAX_FIELD);
        end
        else
        begin
            width_s = dfmt_pkg::calc_t'(width_reg);
        end

        if (zero_case_reg)
        begin
            nd = '0;
        end
        else
        begin
            nd = dfmt_pkg::calc_t'(dfmt_pkg::MAX_DIGITS) - dfmt_pkg::calc_t'(nshift_reg);
        end

        if (prec_on_reg && (dfmt_pkg::calc_t'(prec_reg) > nd))
        begin
            pz = dfmt_pkg::calc_t'(prec_reg) - nd;
        end
        else
        begin
            pz = '0;
        end

        body = sign_len + pz + nd;
        if (width_s > body)
        begin
            pad = width_s - body;
        end
        else
        begin
            pad = '0;
        end
        full   = body + pad;
        rspace = !left_reg && !(zpad_reg && !prec_on_reg);
    end

    // character at the current position
    always_comb
    begin
        in_digits = 1'b0;
        if (sign_on_reg && (pos_reg == sign_pos_reg))
        begin
            emit_ch = sign_ch_reg;
        end
        else if (rspace_reg && (pos_reg < pad_reg))
        begin
            emit_ch = dfmt_pkg::CH_SPACE;
        end
        else if (pos_reg < dstart_reg)
        begin
            emit_ch = dfmt_pkg::CH_ZERO;
        end
        else if (pos_reg < dend_reg)
        begin
            emit_ch   = dfmt_pkg::CH_ZERO + dfmt_pkg::CHAR_W'(top_digit);
            in_digits = 1'b1;
        end
        else
        begin
            emit_ch = dfmt_pkg::CH_SPACE;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dfmt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = dfmt_pkg::ST_CONV;
                end
            end
            dfmt_pkg::ST_CONV:
            begin
                if (conv_done)
                begin
                    state_next = dfmt_pkg::ST_NORM;
                end
            end
            dfmt_pkg::ST_NORM:
            begin
                if (!norm_more)
                begin
                    state_next = dfmt_pkg::ST_PREP;
                end
            end
            dfmt_pkg::ST_PREP:
            begin
                if (full == '0)
                begin
                    state_next = dfmt_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = dfmt_pkg::ST_EMIT;
                end
            end
            dfmt_pkg::ST_EMIT:
            begin
                if (slot_free && emit_last)
                begin
                    state_next = dfmt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dfmt_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        in_ready  = 1'b0;
        emit_load = 1'b0;
        ctrl      = '0;
        case (state_reg)
            dfmt_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                ctrl.clear = in_valid;
            end
            dfmt_pkg::ST_CONV:
            begin
                ctrl.dabble = 1'b1;
            end
            dfmt_pkg::ST_NORM:
            begin
                ctrl.shift_up = norm_more;
            end
            dfmt_pkg::ST_EMIT:
            begin
                emit_load     = slot_free;
                ctrl.shift_up = slot_free && in_digits;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    always_comb
    begin
        if (emit_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dfmt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_reg       <= magnitude;
            conv_cnt_reg  <= '0;
            nshift_reg    <= '0;
            width_reg     <= field_width;
            prec_on_reg   <= precision_given;
            prec_reg      <= min_digits;
            plus_reg      <= force_plus;
            space_reg     <= space_sign;
            zpad_reg      <= zero_pad;
            left_reg      <= left_align;
            neg_reg       <= negative;
            zero_case_reg <= precision_given && (min_digits == '0) && (magnitude == '0);
        end
        else if (ctrl.dabble)
        begin
            mag_reg      <= {mag_reg[dfmt_pkg::MAG_W-2:0], 1'b0};
            conv_cnt_reg <= conv_cnt_reg + dfmt_pkg::CNT_W'(1);
        end
        else if ((state_reg == dfmt_pkg::ST_NORM) && norm_more)
        begin
            nshift_reg <= nshift_reg + dfmt_pkg::ND_W'(1);
        end

        if (state_reg == dfmt_pkg::ST_PREP)
        begin
            if (full > dfmt_pkg::calc_t'(dfmt_pkg::MAX_FIELD))
            begin
                len_reg <= dfmt_pkg::calc_t'(dfmt_pkg::MAX_FIELD);
            end
            else
            begin
                len_reg <= full;
            end
            pad_reg     <= pad;
            sign_on_reg <= sign_on;
            sign_ch_reg <= sign_ch;
            rspace_reg  <= rspace;
            pos_reg     <= '0;
            if (rspace)
            begin
                sign_pos_reg <= pad;
            end
            else
            begin
                sign_pos_reg <= '0;
            end
            if (left_reg)
            begin
                dstart_reg <= sign_len + pz;
                dend_reg   <= sign_len + pz + nd;
            end
            else
            begin
                dstart_reg <= full - nd;
                dend_reg   <= full;
            end
        end
        else if (emit_load)
        begin
            pos_reg <= pos_reg + dfmt_pkg::calc_t'(1);
        end

        if (emit_load)
        begin
            out_char_reg <= emit_ch;
            last_reg     <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_reg;

endmodule

// ===== design/dfmt_checker.sv =====
module dfmt_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [dfmt_pkg::CHAR_W-1:0]    out_char,
    input logic                           last_char
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last_char))
        else $error("output word changed while stalled");

    // conversion keeps the input closed for a while
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("input reopened during conversion");

    // no character appears right after a word is taken
    a_no_early_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("character emitted before conversion");

    // reset empties the output stage
    a_reset_clears: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("output valid during reset");

endmodule

bind decimal_field_formatter_unit dfmt_checker u_dfmt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .last_char (last_char)
);

// ===== tb/decimal_field_formatter_checker.sv =====
`timescale 1ns / 1ps

module decimal_field_formatter_checker
    import dfmt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [MAG_W-1:0]   magnitude,
    input  logic               negative,
    input  logic [WIDTH_W-1:0] field_width,
    input  logic               precision_given,
    input  logic [PREC_W-1:0]  min_digits,
    input  logic               force_plus,
    input  logic               space_sign,
    input  logic               zero_pad,
    input  logic               left_align,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [CHAR_W-1:0]  out_char,
    input  logic               last_char,
    output int                 fail_count,
    output int                 pending
);

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_word_t;

    char_word_t expected_chars[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic format_field(
        input logic [MAG_W-1:0]   mag,
        input logic               neg,
        input logic [WIDTH_W-1:0] width_in,
        input logic               prec_on,
        input logic [PREC_W-1:0]  prec,
        input logic               plus,
        input logic               space,
        input logic               zpad,
        input logic               left
    );
        digit_t            digits [MAX_DIGITS];
        logic [MAG_W-1:0]  rest;
        logic [CHAR_W-1:0] sign_ch;
        logic [CHAR_W-1:0] line [$];
        char_word_t        w;
        int                nd;
        int                width;
        int                sign_len;
        int                prec_zeros;
        int                body;
        int                pad;
        int                kept;
        int                i;

        width = (width_in > MAX_FIELD) ? MAX_FIELD : int'(width_in);

        // digits, least significant first
        nd   = 0;
        rest = mag;
        if (!(prec_on && prec == 0 && mag == 0))
        begin
            do
            begin
                digits[nd] = digit_t'(rest % 10);
                rest       = rest / 10;
                nd++;
            end while (rest != 0 && nd < MAX_DIGITS);
        end

        if (neg)
            sign_ch = CH_MINUS;
        else if (plus)
            sign_ch = CH_PLUS;
        else
            sign_ch = CH_SPACE;
        sign_len = (neg || plus || space) ? 1 : 0;

        prec_zeros = (prec_on && int'(prec) > nd) ? int'(prec) - nd : 0;
        body       = sign_len + prec_zeros + nd;
        pad        = (width > body) ? width - body : 0;

        if (!left && !(zpad && !prec_on))
            repeat (pad) line.push_back(CH_SPACE);
        if (sign_len != 0)
            line.push_back(sign_ch);
        if (!left && zpad && !prec_on)
            repeat (pad) line.push_back(CH_ZERO);
        repeat (prec_zeros) line.push_back(CH_ZERO);
        for (i = nd; i > 0; i--)
            line.push_back(CH_ZERO + CHAR_W'(digits[i-1]));
        if (left)
            repeat (pad) line.push_back(CH_SPACE);

        kept = (line.size() > MAX_FIELD) ? MAX_FIELD : line.size();
        for (i = 0; i < kept; i++)
        begin
            w.ch   = line[i];
            w.last = (i == kept - 1);
            expected_chars.push_back(w);
        end
    endtask

    always @(posedge clk)
    begin
        char_word_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $display("%0t: unexpected char, expected none, got %h last %b",
                             $time, out_char, last_char);
                    fail_count++;
                end
                else
                begin
                    e = expected_chars.pop_front();
                    if (out_char !== e.ch)
                    begin
                        $display("%0t: out_char mismatch, expected %h, got %h",
                                 $time, e.ch, out_char);
                        fail_count++;
                    end
                    if (last_char !== e.last)
                    begin
                        $display("%0t: last_char mismatch, expected %b, got %b",
                                 $time, e.last, last_char);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                format_field(magnitude, negative, field_width, precision_given, min_digits,
                             force_plus, space_sign, zero_pad, left_align);
            pending = expected_chars.size();
        end
    end

endmodule

// ===== tb/tb_decimal_field_formatter_unit.sv =====
`timescale 1ns / 1ps

module tb_decimal_field_formatter_unit;
    import dfmt_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 86;

    typedef struct packed {
        logic [MAG_W-1:0]   magnitude;
        logic               negative;
        logic [WIDTH_W-1:0] field_width;
        logic               precision_given;
        logic [PREC_W-1:0]  min_digits;
        logic               force_plus;
        logic               space_sign;
        logic               zero_pad;
        logic               left_align;
    } fmt_word_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [MAG_W-1:0]   magnitude;
    logic               negative;
    logic [WIDTH_W-1:0] field_width;
    logic               precision_given;
    logic [PREC_W-1:0]  min_digits;
    logic               force_plus;
    logic               space_sign;
    logic               zero_pad;
    logic               left_align;
    logic               out_valid;
    logic               out_ready;
    logic [CHAR_W-1:0]  out_char;
    logic               last_char;

    int fail_count;
    int pending;
    int words_sent = 0;
    int cycles     = 0;
    bit calm       = 1'b0;

    decimal_field_formatter_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .magnitude       (magnitude),
        .negative        (negative),
        .field_width     (field_width),
        .precision_given (precision_given),
        .min_digits      (min_digits),
        .force_plus      (force_plus),
        .space_sign      (space_sign),
        .zero_pad        (zero_pad),
        .left_align      (left_align),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_char        (out_char),
        .last_char       (last_char)
    );

    decimal_field_formatter_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .magnitude       (magnitude),
        .negative        (negative),
        .field_width     (field_width),
        .precision_given (precision_given),
        .min_digits      (min_digits),
        .force_plus      (force_plus),
        .space_sign      (space_sign),
        .zero_pad        (zero_pad),
        .left_align      (left_align),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_char        (out_char),
        .last_char       (last_char),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_decimal_field_formatter_unit NOT OK");
            $finish;
        end
    end

    function automatic fmt_word_t make_word(
        input logic [MAG_W-1:0] mag,
        input logic             neg,
        input int               width,
        input logic             prec_on,
        input int               prec,
        input logic             plus,
        input logic             space,
        input logic             zpad,
        input logic             left
    );
        fmt_word_t w;
        w.magnitude       = mag;
        w.negative        = neg;
        w.field_width     = WIDTH_W'(width);
        w.precision_given = prec_on;
        w.min_digits      = PREC_W'(prec);
        w.force_plus      = plus;
        w.space_sign      = space;
        w.zero_pad        = zpad;
        w.left_align      = left;
        return w;
    endfunction

    function automatic fmt_word_t random_word();
        fmt_word_t        w;
        logic [MAG_W-1:0] p;
        int               k;
        case ($urandom_range(3))
            0: w.magnitude = MAG_W'($urandom_range(999));
            1: w.magnitude = {$urandom, $urandom} >> $urandom_range(63);
            2: w.magnitude = {$urandom, $urandom};
            default:
            begin
                // around powers of ten
                p = 1;
                k = $urandom_range(19);
                repeat (k) p = p * 10;
                w.magnitude = p - MAG_W'($urandom_range(1));
            end
        endcase
        w.negative        = 1'($urandom_range(1));
        w.field_width     = ($urandom_range(99) < 70) ? WIDTH_W'($urandom_range(30))
                                                      : WIDTH_W'($urandom_range(127));
        w.precision_given = 1'($urandom_range(1));
        w.min_digits      = ($urandom_range(99) < 70) ? PREC_W'($urandom_range(25))
                                                      : PREC_W'($urandom_range(63));
        w.force_plus      = 1'($urandom_range(1));
        w.space_sign      = 1'($urandom_range(1));
        w.zero_pad        = 1'($urandom_range(1));
        w.left_align      = 1'($urandom_range(1));
        return w;
    endfunction

    task automatic offer_word(input fmt_word_t w);
        int gap;
        if (!calm)
        begin
            if ($urandom_range(99) < 5)
            begin
                in_valid <= 1'b0;
                gap = $urandom_range(1, 150);
                repeat (gap) @(posedge clk);
            end
            else
            begin
                while ($urandom_range(99) < 22)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                end
            end
        end
        in_valid        <= 1'b1;
        magnitude       <= w.magnitude;
        negative        <= w.negative;
        field_width     <= w.field_width;
        precision_given <= w.precision_given;
        min_digits      <= w.min_digits;
        force_plus      <= w.force_plus;
        space_sign      <= w.space_sign;
        zero_pad        <= w.zero_pad;
        left_align      <= w.left_align;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    // receiver: random stalls, one long hold-off
    initial
    begin
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!held && words_sent >= 30)
            begin
                held      = 1'b1;
                hold_left = 400;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= 22);
        end
    end

    initial
    begin
        logic [MAG_W-1:0] all_ones;
        int               i;
        all_ones = '1;

        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        magnitude       <= '0;
        negative        <= 1'b0;
        field_width     <= '0;
        precision_given <= 1'b0;
        min_digits      <= '0;
        force_plus      <= 1'b0;
        space_sign      <= 1'b0;
        zero_pad        <= 1'b0;
        left_align      <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_word(make_word(0, 0, 0, 0, 0, 0, 0, 0, 0));
        // zero at precision zero: empty field, then padded
        offer_word(make_word(0, 0, 0, 1, 0, 0, 0, 0, 0));
        offer_word(make_word(0, 0, 5, 1, 0, 0, 0, 0, 0));
        offer_word(make_word(0, 0, 1, 1, 0, 0, 1, 0, 0));
        offer_word(make_word(0, 1, 0, 0, 0, 0, 0, 0, 0));
        offer_word(make_word(0, 0, 0, 1, 1, 0, 0, 0, 0));
        offer_word(make_word(all_ones, 1, 0, 0, 0, 1, 0, 0, 0));
        offer_word(make_word(all_ones, 0, 64, 0, 0, 0, 0, 0, 1));
        offer_word(make_word(123, 0, 10, 0, 0, 1, 0, 1, 0));
        offer_word(make_word(42, 0, 6, 0, 0, 0, 1, 0, 1));
        offer_word(make_word(7, 0, 4, 0, 0, 1, 1, 0, 0));
        offer_word(make_word(7, 1, 4, 0, 0, 1, 1, 0, 0));
        // zero padding ignored with a precision or left alignment
        offer_word(make_word(55, 0, 8, 1, 3, 0, 0, 1, 0));
        offer_word(make_word(55, 1, 8, 0, 0, 0, 0, 1, 1));
        offer_word(make_word(9, 0, 127, 0, 0, 0, 0, 0, 0));
        offer_word(make_word(9, 1, 65, 0, 0, 0, 0, 1, 0));
        offer_word(make_word(all_ones, 1, 0, 1, 63, 0, 0, 0, 0));
        offer_word(make_word(all_ones, 0, 127, 1, 63, 1, 1, 1, 1));
        offer_word(make_word(1234, 0, 0, 1, 0, 0, 0, 0, 0));
        offer_word(make_word(5, 1, 20, 0, 0, 0, 0, 1, 0));
        offer_word(make_word(77, 0, 0, 0, 63, 0, 0, 1, 0));
        offer_word(make_word(64'd2147483648, 1, 12, 0, 0, 0, 0, 0, 0));
        offer_word(make_word(64'd10000000000000000000, 0, 21, 0, 0, 0, 1, 1, 0));
        offer_word(make_word(0, 0, 127, 1, 0, 1, 0, 1, 1));

        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            calm = (i >= 60 && i < 85);
            offer_word(random_word());
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_decimal_field_formatter_unit OK");
        else
            $display("tb_decimal_field_formatter_unit NOT OK");
        $finish;
    end

endmodule
